@@ src/pfd_pkg.sv @@
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared constants, codes and helpers for the filtered-derivative PID core.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam logic [32:0] TauQ16     = 33'd260759459;
    localparam logic [13:0] DerivScale = 14'd10000;

    // 1e6 = 64 * 15625; the odd part is divided by reciprocal multiplication,
    // recip = ceil(2^44 / 15625), exact for dividends below 2^30
    localparam logic [13:0] UsPerSOdd   = 14'd15625;
    localparam logic [30:0] UsPerSRecip = 31'd1125899907;

    typedef enum logic [2:0] {
        REG_PROP_GAIN,
        REG_INTEG_GAIN,
        REG_DERIV_GAIN,
        REG_PROP_TRIM,
        REG_INTEG_TRIM,
        REG_DERIV_TRIM,
        REG_ERR_CLAMP
    } t_reg_idx;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_ERR,
        OP_DIVF,
        OP_ENDF,
        OP_MDIFF,
        OP_DIVR,
        OP_ENDR,
        OP_MFILT,
        OP_FILT,
        OP_MINT,
        OP_MDT,
        OP_DIVI,
        OP_ENDI,
        OP_MP,
        OP_MD,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/pfd_div.sv @@
// ----------------------------------------------------------------------------
// pfd_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pfd_div
    import pfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_rem,
    input  logic [32:0] i_den,
    input  logic [4:0]  i_pairs,
    output logic        o_busy,
    output logic [63:0] o_quot
);

    logic [4:0]  r_cnt;
    logic [63:0] r_num;
    logic [32:0] r_rem;
    logic [32:0] r_den;
    logic [63:0] n_num;
    logic [32:0] n_rem;
    logic [33:0] t;

    always_comb begin
        n_num = r_num;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            t = {n_rem, n_num[63]};
            if (t >= {1'b0, r_den}) begin
                n_rem = 33'(t - {1'b0, r_den});
                n_num = {n_num[62:0], 1'b1};
            end else begin
                n_rem = t[32:0];
                n_num = {n_num[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_pairs;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= i_rem;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_num;

endmodule

@@ src/pfd_datapath.sv @@
// ----------------------------------------------------------------------------
// pfd_datapath
// Registers, shared multiplier, divider and output stage of the PID core.
// ----------------------------------------------------------------------------
module pfd_datapath
    import pfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic [31:0] i_setpoint,
    input  logic [31:0] i_measured,
    input  logic [15:0] i_step_time_us,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_drive
);

    logic signed [23:0] r_kp, r_ki, r_kd, r_tp, r_ti, r_td;
    logic [30:0]        r_clamp;
    logic signed [31:0] r_sp, r_ms, r_err, r_prev, r_filt, r_integ, r_raw, r_drive;
    logic [15:0]        r_us, r_f;
    logic signed [24:0] r_gp, r_gi, r_gd;
    logic signed [67:0] r_prod;
    logic signed [43:0] r_acc;
    logic               r_neg, r_oval;
    logic [3:0]         r_ccnt;
    logic [63:0]        r_cq;
    logic [13:0]        r_crem;
    logic [15:0]        r_cdig;

    logic signed [32:0] dsub, diff;
    logic signed [31:0] err_sat, lim, e_cl;
    logic signed [41:0] m_a;
    logic signed [25:0] m_b;
    logic signed [67:0] prod_sh;
    logic [67:0]        prod_abs;
    logic               div_start, div_busy;
    logic [63:0]        div_num, div_quot;
    logic [32:0]        div_rem, div_den;
    logic [4:0]         div_pairs;
    logic signed [63:0] raw_s, inc_s, integ_sum, out_sum;
    logic [29:0]        cd_x, cd_back;
    logic [60:0]        cd_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_tp    <= '0;
            r_ti    <= '0;
            r_td    <= '0;
            r_clamp <= '1;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PROP_GAIN:  r_kp    <= i_cfg_data[23:0];
                REG_INTEG_GAIN: r_ki    <= i_cfg_data[23:0];
                REG_DERIV_GAIN: r_kd    <= i_cfg_data[23:0];
                REG_PROP_TRIM:  r_tp    <= i_cfg_data[23:0];
                REG_INTEG_TRIM: r_ti    <= i_cfg_data[23:0];
                REG_DERIV_TRIM: r_td    <= i_cfg_data[23:0];
                REG_ERR_CLAMP:  r_clamp <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign dsub    = {r_sp[31], r_sp} - {r_ms[31], r_ms};
    assign err_sat = (dsub[32] != dsub[31]) ? (dsub[32] ? 32'sh80000000 : 32'sh7FFFFFFF)
                                            : dsub[31:0];
    assign diff    = {r_err[31], r_err} - {r_prev[31], r_prev};
    assign lim     = {1'b0, r_clamp};
    assign e_cl    = (r_err > lim) ? lim : ((r_err < -lim) ? -lim : r_err);
    assign prod_sh = r_prod >>> 16;
    assign prod_abs = r_prod[67] ? 68'(-r_prod) : r_prod;

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_op)
            OP_MDIFF: begin
                m_a = {{9{diff[32]}}, diff};
                m_b = {12'b0, DerivScale};
            end
            OP_MFILT: begin
                m_a = 42'({{10{r_raw[31]}}, r_raw} - {{10{r_filt[31]}}, r_filt});
                m_b = {10'b0, r_f};
            end
            OP_MINT: begin
                m_a = {{10{e_cl[31]}}, e_cl};
                m_b = {r_gi[24], r_gi};
            end
            OP_MDT: begin
                m_a = {prod_sh[40], prod_sh[40:0]};
                m_b = {10'b0, r_us};
            end
            OP_MP: begin
                m_a = {{10{r_err[31]}}, r_err};
                m_b = {r_gp[24], r_gp};
            end
            OP_MD: begin
                m_a = {{10{r_filt[31]}}, r_filt};
                m_b = {r_gd[24], r_gd};
            end
            default: ;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_rem   = '0;
        div_den   = '0;
        div_pairs = '0;
        case (i_op)
            OP_DIVF: begin
                div_start = 1'b1;
                div_rem   = {1'b0, r_us, 16'b0};
                div_den   = {1'b0, r_us, 16'b0} + TauQ16;
                div_pairs = 5'd8;
            end
            OP_DIVR: begin
                div_start = 1'b1;
                div_num   = {prod_abs[45:0], 18'b0};
                div_den   = {17'b0, r_us};
                div_pairs = 5'd23;
            end
            default: ;
        endcase
    end

    pfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_rem   (div_rem),
        .i_den   (div_den),
        .i_pairs (div_pairs),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // divide by 1e6: drop 6 bits, then four 16-bit digits by 15625,
    // each digit takes a quotient step followed by a remainder step
    assign cd_x    = {r_crem, r_cq[63:48]};
    assign cd_prod = {31'b0, cd_x} * {30'b0, UsPerSRecip};
    assign cd_back = {14'b0, r_cdig} * {16'b0, UsPerSOdd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccnt <= '0;
        end else if (i_op == OP_DIVI) begin
            r_ccnt <= 4'd8;
        end else if (r_ccnt != '0) begin
            r_ccnt <= r_ccnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_DIVI) begin
            r_cq   <= {14'b0, prod_abs[55:6]};
            r_crem <= '0;
        end else if (r_ccnt != '0) begin
            if (!r_ccnt[0]) begin
                r_cdig <= cd_prod[59:44];
            end else begin
                r_crem <= 14'(cd_x - cd_back);
                r_cq   <= {r_cq[47:0], r_cdig};
            end
        end
    end

    assign raw_s     = r_neg ? -{18'b0, div_quot[45:0]} : {18'b0, div_quot[45:0]};
    assign inc_s     = r_neg ? -r_cq : r_cq;
    assign integ_sum = {{32{r_integ[31]}}, r_integ} + inc_s;
    assign out_sum   = {{20{r_acc[43]}}, r_acc} + {{12{prod_sh[51]}}, prod_sh[51:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_filt  <= '0;
            r_integ <= '0;
        end else begin
            case (i_op)
                OP_FILT: r_filt  <= r_filt + prod_sh[31:0];
                OP_ENDI: begin
                    r_integ <= sat32(integ_sum);
                    r_prev  <= r_err;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_sp <= i_setpoint;
                r_ms <= i_measured;
                r_us <= (i_step_time_us == '0) ? 16'd1 : i_step_time_us;
            end
            OP_ERR: begin
                r_err <= err_sat;
                r_gp  <= {r_kp[23], r_kp} + {r_tp[23], r_tp};
                r_gi  <= {r_ki[23], r_ki} + {r_ti[23], r_ti};
                r_gd  <= {r_kd[23], r_kd} + {r_td[23], r_td};
            end
            OP_ENDF:  r_f   <= div_quot[15:0];
            OP_DIVR:  r_neg <= r_prod[67];
            OP_DIVI:  r_neg <= r_prod[67];
            OP_ENDR:  r_raw <= sat32(raw_s);
            OP_OUT:   r_drive <= sat32(out_sum);
            default: ;
        endcase
        if (i_op == OP_MD) begin
            r_acc <= {{12{r_integ[31]}}, r_integ} + prod_sh[43:0];
        end
        if (i_op == OP_MDIFF || i_op == OP_MFILT || i_op == OP_MINT ||
            i_op == OP_MDT || i_op == OP_MP || i_op == OP_MD) begin
            r_prod <= m_a * m_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_op == OP_OUT) begin
            r_oval <= 1'b1;
        end else if (i_out_ready) begin
            r_oval <= 1'b0;
        end
    end

    assign o_stat.div_busy = div_busy || (r_ccnt != '0);
    assign o_stat.out_free = !r_oval || i_out_ready;
    assign o_out_valid     = r_oval;
    assign o_drive         = r_drive;

endmodule

@@ src/pfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfd_ctrl
// Sequencer issuing one datapath op per cycle for each step unless stalled.
// ----------------------------------------------------------------------------
module pfd_ctrl
    import pfd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_op   o_op
);

    typedef enum logic [4:0] {
        S_IDLE, S_ERR, S_FGO, S_FWAIT, S_FEND, S_MDIFF, S_RGO, S_RWAIT, S_REND,
        S_MFILT, S_FILT, S_MINT, S_MDT, S_IGO, S_IWAIT, S_IEND, S_MP, S_MD, S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_ERR;
                        r_in_ready <= 1'b0;
                    end
                end
                S_ERR:   r_state <= S_FGO;
                S_FGO:   r_state <= S_FWAIT;
                S_FWAIT: if (!i_stat.div_busy) r_state <= S_FEND;
                S_FEND:  r_state <= S_MDIFF;
                S_MDIFF: r_state <= S_RGO;
                S_RGO:   r_state <= S_RWAIT;
                S_RWAIT: if (!i_stat.div_busy) r_state <= S_REND;
                S_REND:  r_state <= S_MFILT;
                S_MFILT: r_state <= S_FILT;
                S_FILT:  r_state <= S_MINT;
                S_MINT:  r_state <= S_MDT;
                S_MDT:   r_state <= S_IGO;
                S_IGO:   r_state <= S_IWAIT;
                S_IWAIT: if (!i_stat.div_busy) r_state <= S_IEND;
                S_IEND:  r_state <= S_MP;
                S_MP:    r_state <= S_MD;
                S_MD:    r_state <= S_OUT;
                S_OUT: begin
                    if (i_stat.out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:  o_op = i_in_valid ? OP_LOAD : OP_NOP;
            S_ERR:   o_op = OP_ERR;
            S_FGO:   o_op = OP_DIVF;
            S_FEND:  o_op = OP_ENDF;
            S_MDIFF: o_op = OP_MDIFF;
            S_RGO:   o_op = OP_DIVR;
            S_REND:  o_op = OP_ENDR;
            S_MFILT: o_op = OP_MFILT;
            S_FILT:  o_op = OP_FILT;
            S_MINT:  o_op = OP_MINT;
            S_MDT:   o_op = OP_MDT;
            S_IGO:   o_op = OP_DIVI;
            S_IEND:  o_op = OP_ENDI;
            S_MP:    o_op = OP_MP;
            S_MD:    o_op = OP_MD;
            S_OUT:   o_op = i_stat.out_free ? OP_OUT : OP_NOP;
            default: o_op = OP_NOP;
        endcase
    end

    assign o_in_ready = r_in_ready;

endmodule

@@ src/pid_filtered_derivative_core.sv @@
// ----------------------------------------------------------------------------
// pid_filtered_derivative_core
// Fixed-point positional PID with low-pass filtered derivative term.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | setpoint, measured, step_time_us
//  out     | output    | o_out_valid / i_out_ready | drive
//  cfg     | input     | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
//
//  Per step: two divisions on one radix-4 divider and the divide by 1e6 as four
//  reciprocal digits, each division with its own sequencer wait state, plus the other states.
//  One step in flight; the next beat is taken once the drive is in the output register.
//  A stalled output holds the sequencer in its last state. Config is always ready.
//  Synchronous active-low reset clears state, gains and the output valid.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_core
    import pfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_setpoint,
    input  logic [31:0] i_measured,
    input  logic [15:0] i_step_time_us,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_drive,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_op   op;
    t_stat stat;

    pfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_op       (op)
    );

    pfd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_setpoint     (i_setpoint),
        .i_measured     (i_measured),
        .i_step_time_us (i_step_time_us),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_drive        (o_drive)
    );

    assign o_cfg_ready = 1'b1;

endmodule

@@ src/pfd_checker.sv @@
// ----------------------------------------------------------------------------
// pfd_checker
// Port-level checks for the PID core, bound to the top level.
// ----------------------------------------------------------------------------
module pfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_drive
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_drive))
        else $error("out beat dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("in ready still high after accepting a beat");

    a_result_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared with no step in progress");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset did not clear handshake state");

endmodule

bind pid_filtered_derivative_core pfd_checker u_pfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_drive     (o_drive)
);
